[rtl/min_jerk_goal_tick_generator_core_assert.svh]
// Assertion macros for the minimum-jerk goal generator.
// Used by the top level; the macros expand to nothing when SYNTHESIS is set.
`ifndef MIN_JERK_GOAL_TICK_GENERATOR_CORE_ASSERT_SVH
`define MIN_JERK_GOAL_TICK_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge out of reset.
`define MJG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// Checks that a consequent holds in the cycle after an antecedent.
`define MJG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MJG_ASSERT(lbl, expr, msg)
`define MJG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/mjg_pkg.sv]
// Shared constants for the minimum-jerk goal generator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mjg_pkg;

  // Default number of fraction bits of the profile arithmetic.
  localparam int FRAC_BITS_DEF = 20;

  // Field widths fixed by the interface.
  localparam int TICK_W   = 12;
  localparam int TARGET_W = 16;
  localparam int STEP_W   = 16;
  localparam int COUNT_W  = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TICK = 1'b1;

  // Input item kinds carried in tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

endpackage

[rtl/mjg_div.sv]
// Iterative restoring divider producing s = (k << FracBits) / n with k <= n.
// Depends on mjg_pkg for field widths; one quotient bit per cycle.
`timescale 1ns / 1ps

module mjg_div #(
  parameter int FracBits = mjg_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mjg_pkg::STEP_W-1:0]     num_i,
  input  logic [mjg_pkg::STEP_W-1:0]     den_i,
  output logic                           done_o,
  output logic [FracBits:0]              quot_o
);

  localparam int CntW = $clog2(FracBits + 2);
  localparam int RemW = mjg_pkg::STEP_W + 1;

  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic [FracBits:0]         quot_q, quot_d;
  logic [mjg_pkg::STEP_W-1:0] den_q, den_d;
  logic                      ge;
  logic [RemW-1:0]           diff;

  // One trial subtraction per cycle; the remainder after each trial stays below the divisor.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    ge     = rem_q >= {1'b0, den_q};
    diff   = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(FracBits + 1);
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[FracBits-1:0], ge};
      rem_d  = {diff[RemW-2:0], 1'b0};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/mjg_mul.sv]
// Shared fixed-point multiplier: registered product, rounded half up.
// Depends on no package items other than the parameter default.
`timescale 1ns / 1ps

module mjg_mul #(
  parameter int FracBits = mjg_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic [FracBits:0]    a_i,
  input  logic [FracBits+4:0]  b_i,
  output logic [FracBits+5:0]  res_o
);

  localparam int ProdW = 2 * FracBits + 6;

  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] rounded;

  // The product is registered before rounding.
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  // Add one half of the last kept bit, then drop the fraction bits.
  assign rounded = prod_q + (ProdW'(1) << (FracBits - 1));
  assign res_o   = rounded[ProdW-1:FracBits];

endmodule

[rtl/min_jerk_goal_tick_generator_core.sv]
// Channel  | Direction | Contents
// s_axis   | in        | tuser: op; tdata: start_tick, target_tick, step_count
// m_axis   | out       | tdata: goal_tick, was_clamped, clamp_total; tlast: last
// cfg      | in        | write enable, register index, 12-bit write data
//
// A tick word while moving is accepted, then runs through the bit-serial divider (FracBits + 1
// quotient bits, then the quotient is presented), four uses of the shared multiplier (each a
// multiply state and a capture state), and a finish state.
// A start word is loaded as it is accepted.
// The input is not ready until the goal is handed to the output register; a stalled
// output holds the finished goal there while the next word is accepted.
// Reset is asynchronous and active low; it resets all control state.
// Top level of the minimum-jerk goal generator; uses mjg_pkg, mjg_div, mjg_mul.
`timescale 1ns / 1ps
`include "min_jerk_goal_tick_generator_core_assert.svh"

module min_jerk_goal_tick_generator_core #(
  parameter int FracBits = mjg_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input words.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [47:0]                       s_axis_tdata_i,  // start_tick, target_tick, step_count
  input  logic                              s_axis_tuser_i,  // op
  // Result words.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o,  // goal_tick, was_clamped, clamp_total
  output logic                              m_axis_tlast_o,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [mjg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mjg_pkg::TICK_W-1:0]        cfg_wdata_i
);

  localparam int SW = FracBits + 1;
  localparam int PW = FracBits + 5;
  localparam int RW = FracBits + 6;
  localparam int TW = mjg_pkg::TICK_W;
  localparam int NW = mjg_pkg::STEP_W;
  localparam int GW = TW + 6;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_CAP  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    MS_SQUARE = 2'd0,
    MS_CUBE   = 2'd1,
    MS_SHAPE  = 2'd2,
    MS_OFFSET = 2'd3
  } mul_step_e;

  localparam logic [SW-1:0] SOne = {1'b1, {FracBits{1'b0}}};

  state_e    state_q, state_d;
  mul_step_e mstep_q, mstep_d;

  logic [TW-1:0]  min_tick_q, max_tick_q;
  logic [NW-1:0]  step_index_q, steps_total_q;
  logic [TW-1:0]  start_pos_q;
  logic [NW-1:0]  mag_q;
  logic           neg_q;
  logic           moving_q;
  logic [mjg_pkg::COUNT_W-1:0] clamp_counter_q;

  logic [SW-1:0]  s_q, s2_q, s3_q, sp_q;
  logic [PW-1:0]  p_q;
  logic [NW-1:0]  off_q;

  logic           out_valid_q;
  logic [TW-1:0]  out_goal_q;
  logic           out_clamped_q, out_last_q;
  logic [mjg_pkg::COUNT_W-1:0] out_total_q;

  logic           in_fire, tick_go, start_load, fin_go, last;
  logic           div_done;
  logic [SW-1:0]  div_quot;
  logic [SW-1:0]  mul_a;
  logic [PW-1:0]  mul_b;
  logic [RW-1:0]  mul_res;
  logic [PW-1:0]  poly_pos, poly_neg, poly;
  logic [NW:0]    diff, diff_abs;
  logic [GW-1:0]  raw, g_hi, g_fin, max_e, min_e;
  logic           clamped;
  logic [mjg_pkg::COUNT_W-1:0] count_next;

  // Input handshake and item decode.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign start_load = in_fire && (s_axis_tuser_i == mjg_pkg::OP_START);
  assign tick_go    = in_fire && (s_axis_tuser_i == mjg_pkg::OP_TICK) && moving_q;

  // Signed distance from start to target, kept as sign and magnitude.
  assign diff = {s_axis_tdata_i[27], s_axis_tdata_i[27:12]} - {5'b0, s_axis_tdata_i[11:0]};
  assign diff_abs = diff[NW] ? (~diff + (NW+1)'(1)) : diff;

  mjg_div #(
    .FracBits(FracBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(tick_go),
    .num_i  (step_index_q),
    .den_i  (steps_total_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (mstep_q)
      MS_SQUARE: begin
        mul_a = s_q;
        mul_b = PW'(s_q);
      end
      MS_CUBE: begin
        mul_a = s2_q;
        mul_b = PW'(s_q);
      end
      MS_SHAPE: begin
        mul_a = s3_q;
        mul_b = p_q;
      end
      MS_OFFSET: begin
        mul_a = sp_q;
        mul_b = PW'(mag_q);
      end
      default: begin
        mul_a = s_q;
        mul_b = PW'(s_q);
      end
    endcase
  end

  mjg_mul #(
    .FracBits(FracBits)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .res_o(mul_res)
  );

  // Quintic factor 10 - 15 s + 6 s^2, floored at zero.
  assign poly_pos = (PW'(SOne) << 3) + (PW'(SOne) << 1) + (PW'(s2_q) << 2) + (PW'(s2_q) << 1);
  assign poly_neg = (PW'(s_q) << 4) - PW'(s_q);
  assign poly     = (poly_pos > poly_neg) ? (poly_pos - poly_neg) : '0;

  // Goal position, then the joint range with the minimum taking precedence.
  assign max_e = GW'(max_tick_q);
  assign min_e = GW'(min_tick_q);
  assign raw   = neg_q ? (GW'(start_pos_q) - GW'(off_q)) : (GW'(start_pos_q) + GW'(off_q));
  assign g_hi  = ($signed(raw) > $signed(max_e)) ? max_e : raw;
  assign g_fin = ($signed(g_hi) < $signed(min_e)) ? min_e : g_hi;
  assign clamped = (g_fin != raw);
  assign count_next = (clamped && (clamp_counter_q != '1))
                      ? (clamp_counter_q + mjg_pkg::COUNT_W'(1))
                      : clamp_counter_q;
  assign last   = (step_index_q >= steps_total_q);
  assign fin_go = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    mstep_d = mstep_q;
    unique case (state_q)
      S_IDLE: begin
        if (tick_go) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
          mstep_d = MS_SQUARE;
        end
      end
      S_MUL: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        if (mstep_q == MS_OFFSET) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MUL;
          mstep_d = mul_step_e'(mstep_q + 2'd1);
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and move bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      mstep_q         <= MS_SQUARE;
      min_tick_q      <= '0;
      max_tick_q      <= '1;
      step_index_q    <= '0;
      steps_total_q   <= NW'(1);
      moving_q        <= 1'b0;
      clamp_counter_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mjg_pkg::REG_MIN_TICK: min_tick_q <= cfg_wdata_i;
          mjg_pkg::REG_MAX_TICK: max_tick_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_load) begin
        step_index_q  <= '0;
        steps_total_q <= (s_axis_tdata_i[43:28] == '0) ? NW'(1) : s_axis_tdata_i[43:28];
        moving_q      <= 1'b1;
      end
      if (fin_go) begin
        clamp_counter_q <= count_next;
        if (last) begin
          moving_q <= 1'b0;
        end else begin
          step_index_q <= step_index_q + NW'(1);
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_load) begin
      start_pos_q <= s_axis_tdata_i[11:0];
      neg_q       <= diff[NW];
      mag_q       <= diff_abs[NW-1:0];
    end
    if ((state_q == S_DIV) && div_done) begin
      s_q <= div_quot;
    end
    if (state_q == S_CAP) begin
      case (mstep_q)
        MS_SQUARE: s2_q <= mul_res[SW-1:0];
        MS_CUBE: begin
          s3_q <= mul_res[SW-1:0];
          p_q  <= poly;
        end
        MS_SHAPE:  sp_q <= (mul_res > RW'(SOne)) ? SOne : mul_res[SW-1:0];
        MS_OFFSET: off_q <= mul_res[NW-1:0];
        default: ;
      endcase
    end
    if (fin_go) begin
      out_goal_q    <= g_fin[TW-1:0];
      out_clamped_q <= clamped;
      out_last_q    <= last;
      out_total_q   <= count_next;
    end
  end

  // Output word.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b0, out_total_q, out_clamped_q, out_goal_q};
  assign m_axis_tlast_o  = out_last_q;

  // Checks on the sequencer and move bookkeeping.
  `MJG_ASSERT(a_steps_nonzero, steps_total_q != '0, "step total is zero")
  `MJG_ASSERT(a_index_bound, step_index_q <= steps_total_q, "step index past step total")
  `MJG_ASSERT(a_div_done_in_div, !div_done || (state_q == S_DIV), "divider done outside divide")
  `MJG_ASSERT_NEXT(a_last_ends_move, fin_go && last, !moving_q, "move still active after last goal")

endmodule
